>>> hdl/bounded_priority_queue_evict_lowest_top_assert.svh
// assertion macros for the bounded priority queue
`ifndef BOUNDED_PRIORITY_QUEUE_EVICT_LOWEST_TOP_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_EVICT_LOWEST_TOP_ASSERT_SVH
`ifndef SYNTH
`define BPQEL_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bpqel check failed");
`define BPQEL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpqel check failed");
`define BPQEL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpqel check failed");
`else
`define BPQEL_ASSERT(label, expr)
`define BPQEL_ASSERT_IMP(label, ante, cons)
`define BPQEL_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hdl/bpqel_pkg.sv
// types and constants shared by the priority queue cells and top level
package bpqel_pkg;

	localparam int DEPTH        = 16;
	localparam int PRIO_BITS    = 8;
	localparam int PAYLOAD_BITS = 32;
	localparam int OCC_BITS     = 5;
	localparam int CAP_BITS     = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_EVICT = 2'd2,
		OP_POP   = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [PRIO_BITS-1:0] prio;
		logic [PAYLOAD_BITS-1:0]     data;
	} entry_t;

	typedef struct packed {
		kind_t                       kind;
		logic signed [PRIO_BITS-1:0] priority_req;
		logic [PAYLOAD_BITS-1:0]     payload;
	} item_t;

	typedef struct packed {
		logic                        accepted;
		logic                        evicted;
		logic                        pop_valid;
		logic [PAYLOAD_BITS-1:0]     pop_payload;
		logic signed [PRIO_BITS-1:0] pop_priority;
		logic [OCC_BITS-1:0]         occupancy;
	} result_t;

	// broadcast to every cell
	typedef struct packed {
		op_t    op;
		entry_t ent;
	} ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic   valid;
		logic   ge;
		logic   low;
		entry_t ent;
	} nbr_t;

endpackage

>>> hdl/bounded_priority_queue_evict_lowest_top.sv
// bounded priority queue with lowest-priority eviction, top level
// A command is taken in every cycle that start is high (busy stays low), and its
// result appears on result with done high in the next cycle; the receiver
// cannot stall, so it must take every result when done is set. Entries sit in a
// chain of DEPTH cells kept sorted highest first, oldest first among equals; each
// push, evict or pop updates all cells at once. A push into a full
// queue replaces the oldest lowest entry only if it is strictly higher, else it is
// refused. The capacity register (reset 16, saturated at DEPTH) is written through
// cfg_valid/cfg_data and must only change while no command is outstanding.
`include "bounded_priority_queue_evict_lowest_top_assert.svh"
module bounded_priority_queue_evict_lowest_top #(
	parameter int DEPTH = bpqel_pkg::DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bpqel_pkg::item_t                    cmd,
	output logic                                done,
	output bpqel_pkg::result_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpqel_pkg::CAP_BITS-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > bpqel_pkg::CAP_BITS) ? CNT_W : bpqel_pkg::CAP_BITS;
	localparam bpqel_pkg::nbr_t NBR_HEAD = '{valid: 1'b0, ge: 1'b1, low: 1'b0, ent: '0};
	localparam bpqel_pkg::nbr_t NBR_TAIL = '{valid: 1'b0, ge: 1'b0, low: 1'b0, ent: '0};

	logic [bpqel_pkg::CAP_BITS-1:0]     capacity_q;
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   count_d;
	logic                               done_q;
	bpqel_pkg::result_t                 result_q;
	bpqel_pkg::result_t                 result_d;
	bpqel_pkg::ctl_t                    ctl;
	bpqel_pkg::nbr_t                    cur_w [DEPTH];
	bpqel_pkg::nbr_t                    prv_w [DEPTH];
	bpqel_pkg::nbr_t                    nxt_w [DEPTH];
	logic [DEPTH-1:0]                   vld;
	logic [DEPTH-1:0]                   last;
	logic signed [bpqel_pkg::PRIO_BITS-1:0] tail;
	logic [CMP_W-1:0]                   cap_ext;
	logic [CMP_W-1:0]                   cap_eff;
	logic                               full;
	logic                               win;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prv_w[i] = NBR_HEAD;
		end else begin : g_mid
			assign prv_w[i] = cur_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign nxt_w[i] = NBR_TAIL;
			assign last[i]  = cur_w[i].valid;
		end else begin : g_run
			assign nxt_w[i] = cur_w[i+1];
			assign last[i]  = cur_w[i].valid && !cur_w[i+1].valid;
		end
		assign vld[i] = cur_w[i].valid;

		bpqel_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tail   (tail),
			.prv    (prv_w[i]),
			.nxt    (nxt_w[i]),
			.cur    (cur_w[i])
		);
	end

	// lowest stored priority sits in the last valid cell
	always_comb begin
		tail = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (last[i]) begin
				tail = tail | cur_w[i].ent.prio;
			end
		end
	end

	assign cap_ext = CMP_W'(capacity_q);
	assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
	assign full    = CMP_W'(count_q) >= cap_eff;
	assign win     = vld[0] && ($signed(tail) < $signed(cmd.priority_req));

	always_comb begin
		ctl.ent.prio = cmd.priority_req;
		ctl.ent.data = cmd.payload;
		ctl.op       = bpqel_pkg::OP_HOLD;
		if (start) begin
			unique case (cmd.kind)
				bpqel_pkg::KIND_PUSH: begin
					priority if (!full) begin
						ctl.op = bpqel_pkg::OP_PUSH;
					end else if (win) begin
						ctl.op = bpqel_pkg::OP_EVICT;
					end else begin
						ctl.op = bpqel_pkg::OP_HOLD;
					end
				end
				bpqel_pkg::KIND_POP: begin
					ctl.op = vld[0] ? bpqel_pkg::OP_POP : bpqel_pkg::OP_HOLD;
				end
				default: begin
					ctl.op = bpqel_pkg::OP_HOLD;
				end
			endcase
		end
	end

	always_comb begin
		unique case (ctl.op)
			bpqel_pkg::OP_PUSH:  count_d = count_q + CNT_W'(1);
			bpqel_pkg::OP_POP:   count_d = count_q - CNT_W'(1);
			bpqel_pkg::OP_HOLD:  count_d = count_q;
			bpqel_pkg::OP_EVICT: count_d = count_q;
			default:             count_d = count_q;
		endcase
	end

	always_comb begin
		result_d.accepted     = (ctl.op == bpqel_pkg::OP_PUSH) || (ctl.op == bpqel_pkg::OP_EVICT);
		result_d.evicted      = ctl.op == bpqel_pkg::OP_EVICT;
		result_d.pop_valid    = ctl.op == bpqel_pkg::OP_POP;
		result_d.pop_payload  = (ctl.op == bpqel_pkg::OP_POP) ? cur_w[0].ent.data : '0;
		result_d.pop_priority = (ctl.op == bpqel_pkg::OP_POP) ? cur_w[0].ent.prio : '0;
		result_d.occupancy    = bpqel_pkg::OCC_BITS'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bpqel_pkg::CAP_RESET;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			count_q <= count_d;
			done_q  <= start;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	`BPQEL_ASSERT(a_count_match, $countones(vld) == int'(count_q))
	`BPQEL_ASSERT(a_vld_contig, (vld & (vld + DEPTH'(1))) == '0)
	`BPQEL_ASSERT_IMP(a_evict_full, ctl.op == bpqel_pkg::OP_EVICT, full && vld[0])
	`BPQEL_ASSERT_IMP(a_occ_track, done_q, result_q.occupancy == bpqel_pkg::OCC_BITS'(count_q))
	`BPQEL_ASSERT_NXT(a_empty_pop, start && cmd.kind == bpqel_pkg::KIND_POP && count_q == '0,
		done_q && !result_q.pop_valid && result_q.pop_payload == '0)

endmodule

>>> hdl/bpqel_cell.sv
// one slot of the sorted shift-register queue
module bpqel_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bpqel_pkg::ctl_t                       ctl,
	input  logic signed [bpqel_pkg::PRIO_BITS-1:0] tail,
	input  bpqel_pkg::nbr_t                       prv,
	input  bpqel_pkg::nbr_t                       nxt,
	output bpqel_pkg::nbr_t                       cur
);

	logic              valid_q;
	bpqel_pkg::entry_t ent_q;
	logic              valid_d;
	bpqel_pkg::entry_t ent_d;
	logic              ge;
	logic              low;
	logic              ins;

	// ge: stays ahead of the new item; low: part of the lowest group
	assign ge  = valid_q && ($signed(ent_q.prio) >= $signed(ctl.ent.prio));
	assign low = valid_q && ($signed(ent_q.prio) == $signed(tail));
	assign ins = !ge && prv.ge;

	always_comb begin
		valid_d = valid_q;
		ent_d   = ent_q;
		unique case (ctl.op)
			bpqel_pkg::OP_HOLD: begin
				valid_d = valid_q;
				ent_d   = ent_q;
			end
			bpqel_pkg::OP_PUSH: begin
				priority if (ge) begin
					valid_d = valid_q;
					ent_d   = ent_q;
				end else if (ins) begin
					valid_d = 1'b1;
					ent_d   = ctl.ent;
				end else begin
					valid_d = prv.valid;
					ent_d   = prv.ent;
				end
			end
			bpqel_pkg::OP_EVICT: begin
				// cells past the evicted one keep their place
				priority if (prv.low || ge) begin
					valid_d = valid_q;
					ent_d   = ent_q;
				end else if (ins) begin
					valid_d = 1'b1;
					ent_d   = ctl.ent;
				end else begin
					valid_d = prv.valid;
					ent_d   = prv.ent;
				end
			end
			bpqel_pkg::OP_POP: begin
				valid_d = nxt.valid;
				ent_d   = nxt.ent;
			end
			default: begin
				valid_d = valid_q;
				ent_d   = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign cur.valid = valid_q;
	assign cur.ge    = ge;
	assign cur.low   = low;
	assign cur.ent   = ent_q;

endmodule
